FILE: src/hamm_pkg.sv
// ============================================================================
// hamm_pkg
// Shared types and constants for the heightmap window min/max block.
// ============================================================================
`default_nettype none

package hamm_pkg;

    // Side register limits and reset value.
    localparam logic [3:0] SIDE_LOG2_MIN   = 4'd8;
    localparam logic [3:0] SIDE_LOG2_RESET = 4'd8;
    localparam int         MAX_SIDE_LOG2_DEFAULT = 8;

    // Fixed field widths.
    localparam int COORD_W  = 12;
    localparam int EXTENT_W = 13;
    localparam int HEIGHT_W = 16;
    // Width for origin plus extent compares against the side.
    localparam int SUM_W    = 14;

    // Action codes.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [HEIGHT_W-1:0] height_t;

    // Values reported for a rectangle that is not walked.
    localparam height_t HEIGHT_MIN_INIT = 16'hFFFF;
    localparam height_t HEIGHT_MAX_INIT = 16'h0000;

    // One result item.
    typedef struct packed {
        height_t min_height;
        height_t max_height;
        logic    empty_area;
        logic    out_of_range;
    } result_t;

endpackage

`default_nettype wire

FILE: src/hamm_store.sv
// ============================================================================
// hamm_store
// Height sample memory: one write port and one read port, registered read.
// ============================================================================
`default_nettype none

module hamm_store #(
    parameter int ADDR_W = 16
) (
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic [ADDR_W-1:0]       wr_addr,
    input  wire hamm_pkg::height_t       wr_data,
    input  wire logic                    rd_en,
    input  wire logic [ADDR_W-1:0]       rd_addr,
    output hamm_pkg::height_t            rd_data
);
    import hamm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    height_t mem [DEPTH];
    height_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with a registered output.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/hamm_ctrl.sv
// ============================================================================
// hamm_ctrl
// Item sequencer: handles loads, walks query rectangles through the store
// one sample per cycle, and holds the result register.
// ============================================================================
`default_nettype none

module hamm_ctrl #(
    parameter int MAX_SIDE_LOG2 = hamm_pkg::MAX_SIDE_LOG2_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [3:0]                            side_log2,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  action,
    input  wire logic [hamm_pkg::COORD_W-1:0]          col,
    input  wire logic [hamm_pkg::COORD_W-1:0]          row,
    input  wire logic [hamm_pkg::EXTENT_W-1:0]         area_width,
    input  wire logic [hamm_pkg::EXTENT_W-1:0]         area_height,
    input  wire hamm_pkg::height_t                     sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output hamm_pkg::result_t                          result,
    output logic                                       wr_en,
    output logic [2*MAX_SIDE_LOG2-1:0]                 wr_addr,
    output hamm_pkg::height_t                          wr_data,
    output logic                                       rd_en,
    output logic [2*MAX_SIDE_LOG2-1:0]                 rd_addr,
    input  wire hamm_pkg::height_t                     rd_data
);
    import hamm_pkg::*;

    localparam int XW     = MAX_SIDE_LOG2;
    localparam int ADDR_W = 2 * MAX_SIDE_LOG2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t          state_reg,    state_next;
    logic [XW-1:0]   x_reg,        x_next;
    logic [XW-1:0]   z_reg,        z_next;
    logic [XW-1:0]   x_first_reg,  x_first_next;
    logic [XW-1:0]   x_last_reg,   x_last_next;
    logic [XW-1:0]   z_last_reg,   z_last_next;
    height_t         acc_min_reg,  acc_min_next;
    height_t         acc_max_reg,  acc_max_next;
    logic            rd_valid_reg, rd_valid_next;
    logic            out_valid_reg, out_valid_next;
    result_t         result_reg,   result_next;

    logic            in_fire;
    logic            out_free;
    logic [SUM_W-1:0] side;
    logic [SUM_W-1:0] col_sum;
    logic [SUM_W-1:0] row_sum;
    logic            load_oor;
    logic            q_empty;
    logic            q_oor;
    logic [SUM_W-1:0] x_end;
    logic [SUM_W-1:0] z_end;

    // Handshake.
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Range checks against the active side.
    assign side     = SUM_W'(1) << side_log2;
    assign col_sum  = SUM_W'(col) + SUM_W'(area_width);
    assign row_sum  = SUM_W'(row) + SUM_W'(area_height);
    assign load_oor = (SUM_W'(col) >= side) || (SUM_W'(row) >= side);
    assign q_empty  = (area_width == '0) || (area_height == '0);
    assign q_oor    = (col_sum > side) || (row_sum > side);
    assign x_end    = col_sum - SUM_W'(1);
    assign z_end    = row_sum - SUM_W'(1);

    // Store addressing: entry x + (z << side_log2).
    assign wr_addr = ADDR_W'(col[XW-1:0]) + (ADDR_W'(row[XW-1:0]) << side_log2);
    assign wr_data = sample;
    assign rd_addr = ADDR_W'(x_reg) + (ADDR_W'(z_reg) << side_log2);

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        z_next         = z_reg;
        x_first_next   = x_first_reg;
        x_last_next    = x_last_reg;
        z_last_next    = z_last_reg;
        acc_min_next   = acc_min_reg;
        acc_max_next   = acc_max_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        // The result register empties when its item is taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Fold the sample read in the previous cycle.
        if (rd_valid_reg)
        begin
            if (rd_data < acc_min_reg)
            begin
                acc_min_next = rd_data;
            end
            if (rd_data > acc_max_reg)
            begin
                acc_max_next = rd_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (action == ACT_LOAD)
                    begin
                        wr_en          = !load_oor;
                        result_next    = '{min_height: '0, max_height: '0,
                                           empty_area: 1'b0, out_of_range: load_oor};
                        out_valid_next = 1'b1;
                    end
                    else if (q_empty || q_oor)
                    begin
                        result_next    = '{min_height: HEIGHT_MIN_INIT,
                                           max_height: HEIGHT_MAX_INIT,
                                           empty_area: q_empty, out_of_range: q_oor};
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        x_next       = col[XW-1:0];
                        z_next       = row[XW-1:0];
                        x_first_next = col[XW-1:0];
                        x_last_next  = x_end[XW-1:0];
                        z_last_next  = z_end[XW-1:0];
                        acc_min_next = HEIGHT_MIN_INIT;
                        acc_max_next = HEIGHT_MAX_INIT;
                        state_next   = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                // Issue one read per cycle, row by row.
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                if (x_reg == x_last_reg)
                begin
                    x_next = x_first_reg;
                    if (z_reg == z_last_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        z_next = z_reg + XW'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
            end

            ST_DRAIN:
            begin
                // The last sample is folded on this edge.
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    result_next    = '{min_height: acc_min_reg, max_height: acc_max_reg,
                                       empty_area: 1'b0, out_of_range: 1'b0};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            z_reg         <= '0;
            x_first_reg   <= '0;
            x_last_reg    <= '0;
            z_last_reg    <= '0;
            acc_min_reg   <= HEIGHT_MIN_INIT;
            acc_max_reg   <= HEIGHT_MAX_INIT;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            z_reg         <= z_next;
            x_first_reg   <= x_first_next;
            x_last_reg    <= x_last_next;
            z_last_reg    <= z_last_next;
            acc_min_reg   <= acc_min_next;
            acc_max_reg   <= acc_max_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

FILE: src/heightmap_area_min_max.sv
// ============================================================================
// heightmap_area_min_max
// Square heightmap store with load items and rectangle min/max query items.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  action, col, row, area_width,
//                                           area_height, sample
// out       output     out_valid/out_stall  min_height, max_height,
//                                           empty_area, out_of_range
// cfg       input      cfg_valid/cfg_ready  cfg_data (side_log2)
//
// A load item, an empty query and an out-of-range query are answered from
// the accept step alone. A walked query goes through the accept step, the
// walk (the store has one read port, so the rectangle is read one sample per
// cycle), a step for the read latency and the fold of the last sample, and
// the result step. Only one item is in work at a time. Reset sets side_log2
// to 8; the store contents stay undefined until written. A stalled result
// holds in the output register and blocks new items.
//
`default_nettype none

module heightmap_area_min_max #(
    parameter int MAX_SIDE_LOG2 = hamm_pkg::MAX_SIDE_LOG2_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [3:0]                        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              action,
    input  wire logic [hamm_pkg::COORD_W-1:0]      col,
    input  wire logic [hamm_pkg::COORD_W-1:0]      row,
    input  wire logic [hamm_pkg::EXTENT_W-1:0]     area_width,
    input  wire logic [hamm_pkg::EXTENT_W-1:0]     area_height,
    input  wire logic [hamm_pkg::HEIGHT_W-1:0]     sample,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [hamm_pkg::HEIGHT_W-1:0]          min_height,
    output logic [hamm_pkg::HEIGHT_W-1:0]          max_height,
    output logic                                   empty_area,
    output logic                                   out_of_range
);
    import hamm_pkg::*;

    localparam int         ADDR_W   = 2 * MAX_SIDE_LOG2;
    localparam logic [3:0] LOG2_MAX = 4'(MAX_SIDE_LOG2);

    logic [3:0]        side_log2_reg;
    logic [3:0]        side_log2_active;
    result_t           result;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    height_t           wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    height_t           rd_data;

    // Side register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_log2_reg <= SIDE_LOG2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            side_log2_reg <= cfg_data;
        end
    end

    // Saturate the side to the supported range.
    always_comb
    begin
        if (side_log2_reg < SIDE_LOG2_MIN)
        begin
            side_log2_active = SIDE_LOG2_MIN;
        end
        else if (side_log2_reg > LOG2_MAX)
        begin
            side_log2_active = LOG2_MAX;
        end
        else
        begin
            side_log2_active = side_log2_reg;
        end
    end

    hamm_ctrl #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .side_log2   (side_log2_active),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .col         (col),
        .row         (row),
        .area_width  (area_width),
        .area_height (area_height),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    hamm_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result fields.
    assign min_height   = result.min_height;
    assign max_height   = result.max_height;
    assign empty_area   = result.empty_area;
    assign out_of_range = result.out_of_range;

endmodule

`default_nettype wire
